// ===== hw/rtl/ece_pkg.sv =====
// Shared types and constants of the easing curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package ece_pkg;

   // Default sizes
   localparam int BISECT_STEPS_DEF       = 16;
   localparam int SINE_TABLE_ENTRIES_DEF = 256;

   // Fixed point constants, 24-bit signed working width
   localparam int DW = 24;
   localparam logic signed [DW-1:0] ONE_Q15   = 24'sd32768;
   localparam logic signed [DW-1:0] THREE_Q15 = 24'sd98304;
   localparam logic signed [DW-1:0] BACK_K    = 24'sd55757;
   localparam logic signed [DW-1:0] BACK_K1   = 24'sd88525;
   localparam logic signed [DW-1:0] OUT_MAX   = 24'sd131071;
   localparam logic signed [DW-1:0] OUT_MIN   = -24'sd131072;
   localparam logic signed [DW-1:0] Y_MAX     = 24'sd65536;
   localparam logic signed [DW-1:0] Y_MIN     = -24'sd65536;

   // Register indexes
   localparam logic [2:0] CSR_MODE  = 3'd0;
   localparam logic [2:0] CSR_CURVE = 3'd1;
   localparam logic [2:0] CSR_X1    = 3'd2;
   localparam logic [2:0] CSR_Y1    = 3'd3;
   localparam logic [2:0] CSR_X2    = 3'd4;
   localparam logic [2:0] CSR_Y2    = 3'd5;
   localparam logic [2:0] CSR_TOL   = 3'd6;

   // Builtin curve codes
   localparam logic [3:0] CRV_LINEAR     = 4'd0;
   localparam logic [3:0] CRV_REVERSE    = 4'd1;
   localparam logic [3:0] CRV_SQ_IN      = 4'd2;
   localparam logic [3:0] CRV_SQ_OUT     = 4'd3;
   localparam logic [3:0] CRV_CUBE_IN    = 4'd4;
   localparam logic [3:0] CRV_CUBE_OUT   = 4'd5;
   localparam logic [3:0] CRV_SMOOTH     = 4'd6;
   localparam logic [3:0] CRV_SINE_IN    = 4'd7;
   localparam logic [3:0] CRV_SINE_OUT   = 4'd8;
   localparam logic [3:0] CRV_SINE_INOUT = 4'd9;
   localparam logic [3:0] CRV_BOUNCE     = 4'd10;
   localparam logic [3:0] CRV_COSINE     = 4'd11;
   localparam logic [3:0] CRV_BACK       = 4'd12;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SINE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_BZ_START,
      ST_EVAL,
      ST_CHECK,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/easing_curve_evaluator_top.sv =====
// Easing curve evaluator: builtin curves and cubic bezier bisection on one multiplier.
// Usage:
//   req_* carries one progress item (unsigned Q1.15, values above 1.0 clamp to 1.0).
//   rsp_* returns one eased value (signed Q3.15, saturated) plus a clip flag.
//   csr_* writes the curve registers; csr_ready is always high. Write only while idle.
// Sequencing:
//   All products go through one shared 24x24 multiplier with Q.15 rounding,
//   driven by a small sequencer; req_stall is high while an item is in work.
//   Builtin curves pass through a sine lookup, three multiply steps and a
//   finish step. Bezier mode runs 8 multiplies per curve evaluation, with
//   1 to BISECT_STEPS+1 x-evaluations per item before the y-evaluation.
//   Progress of exactly 0 or 1.0 in bezier mode skips the bisection.
// Reset:
//   Synchronous, active high; registers return to defaults (tolerance 33),
//   the sequencer goes idle and no result is held.
// Stall:
//   A finished result waits in the output register while rsp_stall is high;
//   the next item may already be accepted and worked on, and it holds in its
//   finish step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module easing_curve_evaluator_top
   import ece_pkg::*;
#(
   parameter int BISECT_STEPS       = BISECT_STEPS_DEF,
   parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_progress,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [17:0]      rsp_eased_value,
   output logic                    rsp_clipped,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [17:0]        csr_wdata
);

   localparam int NW    = $clog2(BISECT_STEPS + 1);
   localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int POS_W = 15 + IDX_W;

   // Quarter-wave sine sample k, Q.15, by truncated Taylor series
   function automatic logic [15:0] sine_sample(input int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint          s;
      x = 64'(k) * 64'd1686629713 / 64'(SINE_TABLE_ENTRIES);
      term = x;
      s = signed'(x);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd6;   s = s - signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd20;  s = s + signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd42;  s = s - signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd72;  s = s + signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd110; s = s - signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd156; s = s + signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd210; s = s - signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd272; s = s + signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd342; s = s - signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd420; s = s + signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd506; s = s - signed'(term);
      term = (((term * x) >> 30) * x) >> 30; term = term / 64'd600; s = s + signed'(term);
      if (s < 0) begin
         s = 0;
      end
      return 16'((s + 64'sd16384) >>> 15);
   endfunction

   // Constant sine table
   logic [15:0] sine_rom [0:SINE_TABLE_ENTRIES];
   for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_sine
      assign sine_rom[k] = sine_sample(k);
   end

   // Registers
   state_type state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [3:0]           curve_ff, curve_in;
   logic [15:0]          x1_ff, x1_in, x2_ff, x2_in;
   logic [17:0]          y1_ff, y1_in, y2_ff, y2_in;
   logic [9:0]           tol_ff, tol_in;
   logic [15:0]          p_ff, p_in;
   logic signed [DW-1:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in;
   logic [15:0]          lo_ff, lo_in, d_ff, d_in;
   logic [14:0]          frac_ff, frac_in;
   logic                 neg_ff, neg_in;
   logic [15:0]          t_ff, t_in, blo_ff, blo_in, bhi_ff, bhi_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [2:0]           zstep_ff, zstep_in;
   logic                 phase_y_ff, phase_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [17:0]   value_ff, value_in;
   logic                 clip_ff, clip_in;

   // Shared multiplier with Q.15 round half up
   logic signed [DW-1:0]   mul_a, mul_b, qm;
   logic signed [2*DW-1:0] prod, prod_rnd;
   assign prod     = mul_a * mul_b;
   assign prod_rnd = prod + 48'sd16384;
   assign qm       = prod_rnd[DW+14:15];

   // Common operands
   logic signed [DW-1:0] p_s, u_rev, u_fwd, t_s, s_s, ca, cb, x1c, x2c, y1c, y2c;
   logic signed [DW-1:0] y1_sx, y2_sx;
   logic                 endpoint, out_free;
   assign p_s      = signed'(DW'(p_ff));
   assign u_rev    = ONE_Q15 - p_s;
   assign u_fwd    = p_s - ONE_Q15;
   assign t_s      = signed'(DW'(t_ff));
   assign s_s      = ONE_Q15 - t_s;
   assign x1c      = (x1_ff > 16'd32768) ? ONE_Q15 : signed'(DW'(x1_ff));
   assign x2c      = (x2_ff > 16'd32768) ? ONE_Q15 : signed'(DW'(x2_ff));
   assign y1_sx    = DW'(signed'(y1_ff));
   assign y2_sx    = DW'(signed'(y2_ff));
   assign y1c      = (y1_sx > Y_MAX) ? Y_MAX : ((y1_sx < Y_MIN) ? Y_MIN : y1_sx);
   assign y2c      = (y2_sx > Y_MAX) ? Y_MAX : ((y2_sx < Y_MIN) ? Y_MIN : y2_sx);
   assign ca       = phase_y_ff ? y1c : x1c;
   assign cb       = phase_y_ff ? y2c : x2c;
   assign endpoint = (p_ff == 16'd0) || (p_ff == 16'd32768);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sine phase and table lookup
   logic [18:0]      ph;
   logic [15:0]      fq, tab_lo, tab_hi;
   logic [POS_W-1:0] pos;
   logic [IDX_W-1:0] idx, idx_hi;
   always_comb begin
      case (curve_ff)
         CRV_SINE_IN:    ph = 19'(p_ff) + 19'd32768;
         CRV_SINE_INOUT: ph = (19'(p_ff) << 1) + 19'd32768;
         CRV_BOUNCE:     ph = 19'(p_ff) << 1;
         CRV_COSINE:     ph = (19'(p_ff) << 2) + 19'd32768;
         default:        ph = 19'(p_ff);
      endcase
      fq     = ph[15] ? (16'd32768 - {1'b0, ph[14:0]}) : {1'b0, ph[14:0]};
      pos    = POS_W'(fq) * POS_W'(SINE_TABLE_ENTRIES);
      idx    = pos[POS_W-1:15];
      idx_hi = (idx >= IDX_W'(SINE_TABLE_ENTRIES)) ? idx : idx + 1'b1;
      tab_lo = sine_rom[idx];
      tab_hi = sine_rom[idx_hi];
   end

   // Bisection test
   logic signed [DW:0] diff, adiff;
   logic               bz_done;
   assign diff    = (DW + 1)'(p_s) - (DW + 1)'(r2_ff);
   assign adiff   = diff[DW] ? -diff : diff;
   assign bz_done = (n_ff == NW'(BISECT_STEPS)) || (adiff <= (DW + 1)'(tol_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = mode_ff ? ST_BZ_START : ST_SINE;
         ST_SINE:     state_in = ST_MUL1;
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_MUL3;
         ST_MUL3:     state_in = ST_FIN;
         ST_BZ_START: state_in = endpoint ? ST_FIN : ST_EVAL;
         ST_EVAL:     if (zstep_ff == 3'd7) state_in = phase_y_ff ? ST_FIN : ST_CHECK;
         ST_CHECK:    state_in = ST_EVAL;
         ST_FIN:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   logic signed [DW-1:0] sv, wv, res;
   logic [15:0]          nlo, nhi;
   always_comb begin
      mode_in = mode_ff; curve_in = curve_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff; tol_in = tol_ff;
      p_in = p_ff; r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff;
      lo_in = lo_ff; d_in = d_ff; frac_in = frac_ff; neg_in = neg_ff;
      t_in = t_ff; blo_in = blo_ff; bhi_in = bhi_ff; n_in = n_ff;
      zstep_in = zstep_ff; phase_y_in = phase_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      value_in = value_ff; clip_in = clip_ff;
      mul_a = p_s; mul_b = p_s;
      nlo = blo_ff; nhi = bhi_ff;
      sv = '0; wv = '0; res = p_s;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:  mode_in  = csr_wdata[0];
            CSR_CURVE: curve_in = csr_wdata[3:0];
            CSR_X1:    x1_in    = csr_wdata[15:0];
            CSR_Y1:    y1_in    = csr_wdata;
            CSR_X2:    x2_in    = csr_wdata[15:0];
            CSR_Y2:    y2_in    = csr_wdata;
            CSR_TOL:   tol_in   = csr_wdata[9:0];
            default:   ;
         endcase
      end

      case (state_ff)
         // Latch clamped progress
         ST_IDLE: begin
            if (req_valid) p_in = (req_progress > 16'd32768) ? 16'd32768 : req_progress;
         end
         // Fetch sine samples
         ST_SINE: begin
            lo_in   = tab_lo;
            d_in    = (tab_hi >= tab_lo) ? tab_hi - tab_lo : 16'd0;
            frac_in = pos[14:0];
            neg_in  = ph[16];
         end
         ST_MUL1: begin
            case (curve_ff)
               CRV_SQ_OUT: begin mul_a = u_rev; mul_b = u_rev; end
               CRV_CUBE_OUT, CRV_BACK: begin mul_a = u_fwd; mul_b = u_fwd; end
               CRV_SINE_IN, CRV_SINE_OUT, CRV_SINE_INOUT, CRV_BOUNCE, CRV_COSINE: begin
                  mul_a = signed'(DW'(d_ff));
                  mul_b = signed'(DW'(frac_ff));
               end
               default: ;
            endcase
            r0_in = qm;
         end
         ST_MUL2: begin
            case (curve_ff)
               CRV_CUBE_IN:  begin mul_a = r0_ff; mul_b = p_s;   r0_in = qm; end
               CRV_CUBE_OUT: begin mul_a = r0_ff; mul_b = u_fwd; r0_in = qm; end
               CRV_SMOOTH: begin
                  mul_a = r0_ff;
                  mul_b = THREE_Q15 - (p_s <<< 1);
                  r0_in = qm;
               end
               CRV_BACK:     begin mul_a = BACK_K1; mul_b = u_fwd; r1_in = qm; end
               default: ;
            endcase
         end
         ST_MUL3: begin
            if (curve_ff == CRV_BACK) begin
               mul_a = r0_ff;
               mul_b = r1_ff + BACK_K;
               r0_in = qm;
            end
         end
         // Start bisection at the midpoint
         ST_BZ_START: begin
            t_in = 16'd16384; blo_in = 16'd0; bhi_in = 16'd32768;
            n_in = '0; zstep_in = 3'd0; phase_y_in = 1'b0;
         end
         // One bezier evaluation, one product per step
         ST_EVAL: begin
            zstep_in = zstep_ff + 3'd1;
            case (zstep_ff)
               3'd0: begin mul_a = s_s;   mul_b = s_s; r0_in = qm; end
               3'd1: begin mul_a = s_s;   mul_b = t_s; r1_in = qm; end
               3'd2: begin mul_a = t_s;   mul_b = t_s; r2_in = qm; end
               3'd3: begin mul_a = r0_ff; mul_b = t_s; r0_in = qm; end
               3'd4: begin mul_a = r1_ff; mul_b = t_s; r1_in = qm; end
               3'd5: begin mul_a = r2_ff; mul_b = t_s; r2_in = qm; end
               3'd6: begin
                  mul_a = (r0_ff <<< 1) + r0_ff; mul_b = ca; r2_in = r2_ff + qm;
               end
               default: begin
                  mul_a = (r1_ff <<< 1) + r1_ff; mul_b = cb; r2_in = r2_ff + qm;
               end
            endcase
         end
         // Narrow the interval or move on to y
         ST_CHECK: begin
            zstep_in = 3'd0;
            if (bz_done) begin
               phase_y_in = 1'b1;
            end else begin
               if (p_s > r2_ff) nlo = t_ff;
               else nhi = t_ff;
               blo_in = nlo;
               bhi_in = nhi;
               t_in   = 16'((17'(nlo) + 17'(nhi)) >> 1);
               n_in   = n_ff + 1'b1;
            end
         end
         // Form the result and saturate into the output register
         ST_FIN: begin
            sv = signed'(DW'(lo_ff)) + r0_ff;
            if (neg_ff) sv = -sv;
            wv = ONE_Q15 - sv;
            if (mode_ff) begin
               res = endpoint ? p_s : r2_ff;
            end else begin
               case (curve_ff)
                  CRV_REVERSE:                          res = u_rev;
                  CRV_SQ_IN, CRV_CUBE_IN, CRV_SMOOTH:   res = r0_ff;
                  CRV_SQ_OUT:                           res = ONE_Q15 - r0_ff;
                  CRV_CUBE_OUT, CRV_BACK:               res = r0_ff + ONE_Q15;
                  CRV_SINE_IN:                          res = wv;
                  CRV_SINE_OUT, CRV_BOUNCE:             res = sv;
                  CRV_SINE_INOUT, CRV_COSINE:           res = (wv + 24'sd1) >>> 1;
                  default:                              res = p_s;
               endcase
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (res > OUT_MAX) begin
                  value_in = OUT_MAX[17:0]; clip_in = 1'b1;
               end else if (res < OUT_MIN) begin
                  value_in = OUT_MIN[17:0]; clip_in = 1'b1;
               end else begin
                  value_in = res[17:0]; clip_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         curve_ff     <= CRV_LINEAR;
         x1_ff        <= '0;
         y1_ff        <= '0;
         x2_ff        <= '0;
         y2_ff        <= '0;
         tol_ff       <= 10'd33;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         curve_ff     <= curve_in;
         x1_ff        <= x1_in;
         y1_ff        <= y1_in;
         x2_ff        <= x2_in;
         y2_ff        <= y2_in;
         tol_ff       <= tol_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      r2_ff      <= r2_in;
      lo_ff      <= lo_in;
      d_ff       <= d_in;
      frac_ff    <= frac_in;
      neg_ff     <= neg_in;
      t_ff       <= t_in;
      blo_ff     <= blo_in;
      bhi_ff     <= bhi_in;
      n_ff       <= n_in;
      zstep_ff   <= zstep_in;
      phase_y_ff <= phase_y_in;
      value_ff   <= value_in;
      clip_ff    <= clip_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_eased_value = value_ff;
   assign rsp_clipped     = clip_ff;
   assign csr_ready       = 1'b1;

endmodule
`default_nettype wire

// ===== hw/rtl/ece_checker.sv =====
// Port-level checks of the easing curve evaluator and their binding.
`timescale 1ns / 1ps
`default_nettype none
module ece_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic signed [17:0] rsp_eased_value,
   input wire logic              rsp_clipped
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eased_value) && $stable(rsp_clipped))
      else $error("stalled result changed");

   // Go busy once an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled while item in work");

   // Clip only at the range limits
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (rsp_eased_value == 18'h1FFFF) || (rsp_eased_value == 18'h20000))
      else $error("clipped result not at a limit");

   // Come out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind easing_curve_evaluator_top ece_checker u_ece_checker (.*);
`default_nettype wire

// ===== tb/sv/easing_curve_evaluator_top_test.sv =====
// Self-checking testbench of the easing curve evaluator: builtin and bezier curves.
`timescale 1ns / 1ps
module easing_curve_evaluator_top_test;
   import ece_pkg::*;

   typedef struct {
      logic signed [17:0] eased;
      bit                 clip;
   } eased_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [15:0]        req_progress = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [17:0] rsp_eased_value;
   logic               rsp_clipped;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [17:0]        csr_wdata = '0;

   easing_curve_evaluator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_progress(req_progress),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_eased_value(rsp_eased_value), .rsp_clipped(rsp_clipped),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the curve registers
   bit         shadow_mode;
   bit [3:0]   shadow_curve;
   bit [15:0]  shadow_x1, shadow_x2;
   bit [17:0]  shadow_y1, shadow_y2;
   bit [9:0]   shadow_tol;
   bit [31:0]  quarter_wave [0:256];

   eased_item_type pending_eased[$];
   int  error_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  phases_run = 0;
   int  hold_cycles = 0;
   bit  quiet = 1'b0;

   function automatic longint rnd_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint qm(longint a, longint b);
      return rnd_shift(a * b, 15);
   endfunction

   // Quarter-wave sine samples from a Taylor series in Q30
   function automatic void fill_quarter_wave();
      longint unsigned x, term;
      longint sum;
      for (int k = 0; k <= 256; k++) begin
         x = longint'(k) * 64'd1686629713 / 256;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 12; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / (longint'(2 * n) * longint'(2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         quarter_wave[k] = 32'((longint'(sum) + 16384) >> 15);
      end
   endfunction

   function automatic longint quarter_sine(bit [31:0] f);
      bit [31:0] pos, idx, frac, lo, hi, d;
      pos = f * 256;
      idx = pos >> 15;
      frac = pos & 32767;
      if (idx >= 256) return quarter_wave[256];
      lo = quarter_wave[idx];
      hi = quarter_wave[idx + 1];
      d = (hi >= lo) ? hi - lo : 0;
      return longint'(lo) + longint'((d * frac + 16384) >> 15);
   endfunction

   function automatic longint turn_sine(bit [31:0] ph);
      bit [1:0]  quad;
      bit [31:0] f;
      longint    v;
      quad = ph[16:15];
      f = ph & 32767;
      v = quad[0] ? quarter_sine(32768 - f) : quarter_sine(f);
      return quad[1] ? -v : v;
   endfunction

   function automatic longint cubic_at(longint a, longint b, longint t);
      longint s;
      s = 32768 - t;
      return qm(3 * qm(qm(s, s), t), a) + qm(3 * qm(qm(s, t), t), b) + qm(qm(t, t), t);
   endfunction

   function automatic longint y_clamped(bit [17:0] v);
      longint y;
      y = longint'($signed(v));
      if (y > 65536) y = 65536;
      if (y < -65536) y = -65536;
      return y;
   endfunction

   function automatic longint builtin_eased(longint p);
      bit [31:0] up;
      longint    u;
      up = 32'(p);
      case (shadow_curve)
         CRV_REVERSE:    return 32768 - p;
         CRV_SQ_IN:      return qm(p, p);
         CRV_SQ_OUT:     begin u = 32768 - p; return 32768 - qm(u, u); end
         CRV_CUBE_IN:    return qm(qm(p, p), p);
         CRV_CUBE_OUT:   begin u = p - 32768; return qm(qm(u, u), u) + 32768; end
         CRV_SMOOTH:     return qm(qm(p, p), 98304 - 2 * p);
         CRV_SINE_IN:    return 32768 - turn_sine(up + 32768);
         CRV_SINE_OUT:   return turn_sine(up);
         CRV_SINE_INOUT: return rnd_shift(32768 - turn_sine(2 * up + 32768), 1);
         CRV_BOUNCE:     return turn_sine(2 * up);
         CRV_COSINE:     return rnd_shift(32768 - turn_sine(4 * up + 32768), 1);
         CRV_BACK: begin
            u = p - 32768;
            return 32768 + qm(qm(u, u), qm(88525, u) + 55757);
         end
         default:        return p;
      endcase
   endfunction

   function automatic longint bezier_eased(longint p);
      longint x1, x2, lo, hi, t, x, d;
      if (p == 0 || p >= 32768) return p;
      x1 = (shadow_x1 > 32768) ? 32768 : shadow_x1;
      x2 = (shadow_x2 > 32768) ? 32768 : shadow_x2;
      lo = 0;
      hi = 32768;
      t = 16384;
      x = cubic_at(x1, x2, t);
      for (int n = 0; n < 16; n++) begin
         d = p - x;
         if (d < 0) d = -d;
         if (d <= shadow_tol) break;
         if (p > x) lo = t;
         else hi = t;
         t = (lo + hi) / 2;
         x = cubic_at(x1, x2, t);
      end
      return cubic_at(y_clamped(shadow_y1), y_clamped(shadow_y2), t);
   endfunction

   function automatic eased_item_type predict_eased(bit [15:0] progress);
      eased_item_type res;
      longint p, r;
      p = (progress > 32768) ? 32768 : progress;
      r = shadow_mode ? bezier_eased(p) : builtin_eased(p);
      res.clip = 1'b0;
      if (r > 131071) begin r = 131071; res.clip = 1'b1; end
      else if (r < -131072) begin r = -131072; res.clip = 1'b1; end
      res.eased = 18'(r);
      return res;
   endfunction

   // Drive the receiver stall: forced hold, random idling, or quiet stretch
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 19);
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      eased_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_eased.size() == 0) begin
            $error("result with no item outstanding: eased_value %0d", rsp_eased_value);
            error_count++;
         end else begin
            want = pending_eased.pop_front();
            if (rsp_eased_value !== want.eased) begin
               $error("eased_value expected %0d actual %0d", want.eased, rsp_eased_value);
               error_count++;
            end
            if (rsp_clipped !== want.clip) begin
               $error("clipped expected %0d actual %0d", want.clip, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   // Write one register, then leave the port idle
   task automatic write_reg(input logic [2:0] idx, input bit [17:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:  shadow_mode = data[0];
         CSR_CURVE: shadow_curve = data[3:0];
         CSR_X1:    shadow_x1 = data[15:0];
         CSR_Y1:    shadow_y1 = data;
         CSR_X2:    shadow_x2 = data[15:0];
         CSR_Y2:    shadow_y2 = data;
         CSR_TOL:   shadow_tol = data[9:0];
         default:   ;
      endcase
      @(posedge clock);
   endtask

   // Offer one item, hold it until accepted, then maybe leave the input idle
   task automatic send_progress(input bit [15:0] progress);
      req_valid <= 1'b1;
      req_progress <= progress;
      do @(posedge clock); while (req_stall);
      pending_eased.push_back(predict_eased(progress));
      items_sent++;
      if (!quiet && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for all results, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_eased.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      phases_run++;
   endtask

   function automatic bit [15:0] pick_progress();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return 16'($urandom_range(32769, 65535));
         3:       return 16'($urandom_range(0, 64));
         4:       return 16'($urandom_range(32700, 32768));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic bit [17:0] pick_y();
      case ($urandom_range(0, 5))
         0:       return 18'h10000;
         1:       return 18'h30000;
         2:       return 18'($urandom);
         default: return 18'($signed($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic bit [17:0] pick_x();
      case ($urandom_range(0, 5))
         0:       return 18'd0;
         1:       return 18'd32768;
         2:       return 18'($urandom_range(32769, 65535));
         default: return 18'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic test_defaults();
      send_progress(16'd0);
      send_progress(16'd12345);
      send_progress(16'd32768);
      send_progress(16'hFFFF);
      drain();
   endtask

   task automatic test_builtin_curves();
      write_reg(CSR_MODE, 18'd0);
      for (int c = 0; c < 16; c++) begin
         write_reg(CSR_CURVE, 18'(c));
         send_progress(c[0] ? 16'd8192 : 16'd24576);
         if (c >= CRV_SINE_IN && c <= CRV_BACK) send_progress(16'd32767);
         drain();
      end
   endtask

   task automatic test_bezier_directed();
      write_reg(CSR_MODE, 18'd1);
      write_reg(CSR_X1, 18'd8192);
      write_reg(CSR_Y1, 18'h30000);
      write_reg(CSR_X2, 18'd65535);
      write_reg(CSR_Y2, 18'h1FFFF);
      write_reg(CSR_TOL, 18'd0);
      write_reg(3'd7, 18'h3FFFF);
      send_progress(16'd0);
      send_progress(16'd1);
      send_progress(16'd16384);
      send_progress(16'd32768);
      send_progress(16'd40000);
      drain();
      write_reg(CSR_TOL, 18'd1023);
      send_progress(16'd20000);
      drain();
   endtask

   task automatic test_random(input int phases);
      for (int ph = 0; ph < phases; ph++) begin
         if (ph == 0 || ph == phases - 1) begin
            write_reg(CSR_TOL, 18'($urandom_range(0, 1) ? 1023 : 0));
         end else begin
            write_reg(CSR_TOL, 18'($urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom));
         end
         write_reg(CSR_MODE, 18'($urandom_range(0, 2) == 0));
         write_reg(CSR_CURVE, 18'($urandom));
         write_reg(CSR_X1, pick_x());
         write_reg(CSR_Y1, pick_y());
         write_reg(CSR_X2, pick_x());
         write_reg(CSR_Y2, pick_y());
         quiet = (ph % 7 == 3);
         // Fill the block while the receiver holds off
         if (ph % 9 == 4) hold_cycles = 400;
         repeat (60) send_progress(pick_progress());
         drain();
      end
      quiet = 1'b0;
   endtask

   initial begin
      fill_quarter_wave();
      shadow_mode = 0;
      shadow_curve = 0;
      shadow_x1 = 0;
      shadow_x2 = 0;
      shadow_y1 = 0;
      shadow_y2 = 0;
      shadow_tol = 33;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_builtin_curves();
      test_bezier_directed();
      test_random(27);
      $display("Sent %0d progress items over %0d register settings, %0d results checked.",
               items_sent, phases_run, results_seen);
      $display("Covered all curve codes, bezier extremes, output stall and input backpressure.");
      if (error_count == 0 && pending_eased.size() == 0) begin
         $display("** easing_curve_evaluator_top: PASSED **");
      end else begin
         $display("** easing_curve_evaluator_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("** easing_curve_evaluator_top: FAILED **");
      $finish;
   end

endmodule
